FILE: rtl/core/gregorian_date_difference_unit_defines.svh
// assertion macros used by the controller rtl
`ifndef GREGORIAN_DATE_DIFFERENCE_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define GDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdd assertion failed");

// next-cycle implication, reset masked
`define GDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdd assertion failed");

`endif

FILE: rtl/core/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int LAST_YEAR = 9999;
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int DIFF_W    = 23;
    localparam int SER_W     = 23;
    localparam int ADJ_W     = 25;
    localparam int DIFF_MAX  = 4194303;

    // x / 25 as (x * RECIP_25) >> RECIP_SH, exact for x below 4096
    localparam int Q4_W      = YEAR_W - 2;
    localparam int RECIP_W   = 13;
    localparam int RECIP_25  = 5243;
    localparam int RECIP_SH  = 17;
    localparam int PROD_W    = Q4_W + RECIP_W;
    localparam int QUO_W     = PROD_W - RECIP_SH;
    localparam int CUM_W     = 9;

    localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_DEC = 4'd12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic sel;
        logic out_load;
    } t_dp_cmd;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [CUM_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [CUM_W-1:0] cum;
        case (m)
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        if (leap && m > M_FEB) begin
            cum = cum + 9'd1;
        end
        return cum;
    endfunction

endpackage

FILE: rtl/core/gdd_datapath.sv
`timescale 1ns / 1ps

module gdd_datapath (
    input  logic                           i_clk,
    input  gdd_pkg::t_dp_cmd               i_cmd,
    input  logic [gdd_pkg::YEAR_W-1:0]     i_first_year,
    input  logic [gdd_pkg::MONTH_W-1:0]    i_first_month,
    input  logic [gdd_pkg::DAY_W-1:0]      i_first_day,
    input  logic [gdd_pkg::YEAR_W-1:0]     i_second_year,
    input  logic [gdd_pkg::MONTH_W-1:0]    i_second_month,
    input  logic [gdd_pkg::DAY_W-1:0]      i_second_day,
    input  logic                           i_count_last_day,
    output logic signed [gdd_pkg::DIFF_W-1:0] o_day_difference,
    output logic                           o_bad_date
);
    import gdd_pkg::*;

    logic [YEAR_W-1:0]  r_y0, r_y1;
    logic [MONTH_W-1:0] r_m0, r_m1;
    logic [DAY_W-1:0]   r_d0, r_d1;
    logic               r_cnt;
    logic [YEAR_W-1:0]  r_p;
    logic [SER_W-1:0]   r_p365;
    logic [PROD_W-1:0]  r_mp, r_my;
    logic [SER_W-1:0]   r_sd0, r_sd1;
    logic               r_bad;
    logic signed [DIFF_W-1:0] r_diff;
    logic               r_bad_out;

    logic [YEAR_W-1:0]  y, p;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [Q4_W-1:0]    y4;
    logic [QUO_W-1:0]   p100, p400, qy;
    logic [Q4_W-1:0]    rem;
    logic               leap, ok;
    logic [SER_W-1:0]   serial;
    logic signed [ADJ_W-1:0] diff, adj, clamped;

    assign y = i_cmd.sel ? r_y1 : r_y0;
    assign m = i_cmd.sel ? r_m1 : r_m0;
    assign d = i_cmd.sel ? r_d1 : r_d0;
    assign p = y - YEAR_W'(1);
    assign y4 = y[YEAR_W-1:2];

    // leap year, date check and serial day from registered products
    always_comb begin
        p100 = r_mp[PROD_W-1:RECIP_SH];
        p400 = p100 >> 2;
        qy   = r_my[PROD_W-1:RECIP_SH];
        rem  = y4 - Q4_W'(qy) * Q4_W'(25);
        leap = (y[1:0] == 2'd0) && ((rem != '0) || (qy[1:0] == 2'd0));
        ok   = (y != '0) && (y <= YEAR_W'(LAST_YEAR)) &&
               (m >= M_JAN) && (m <= M_DEC) &&
               (d != '0) && (d <= month_len(m, leap));
        serial = r_p365 + SER_W'(r_p >> 2) - SER_W'(p100) + SER_W'(p400) +
                 SER_W'(days_before(m, leap)) + SER_W'(d);
    end

    // signed difference with last-day adjustment and saturation
    always_comb begin
        diff = $signed({2'b00, r_sd1}) - $signed({2'b00, r_sd0});
        if (diff >= 0) begin
            adj = diff + ADJ_W'(r_cnt);
        end else begin
            adj = diff - ADJ_W'(r_cnt);
        end
        if (adj > ADJ_W'(DIFF_MAX)) begin
            clamped = ADJ_W'(DIFF_MAX);
        end else if (adj < -ADJ_W'(DIFF_MAX)) begin
            clamped = -ADJ_W'(DIFF_MAX);
        end else begin
            clamped = adj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y0  <= i_first_year;
            r_m0  <= i_first_month;
            r_d0  <= i_first_day;
            r_y1  <= i_second_year;
            r_m1  <= i_second_month;
            r_d1  <= i_second_day;
            r_cnt <= i_count_last_day;
        end
        if (i_cmd.mul) begin
            r_p    <= p;
            r_p365 <= SER_W'(p) * SER_W'(365);
            r_mp   <= PROD_W'(p[YEAR_W-1:2]) * PROD_W'(RECIP_25);
            r_my   <= PROD_W'(y4) * PROD_W'(RECIP_25);
        end
        if (i_cmd.acc) begin
            if (i_cmd.sel) begin
                r_sd1 <= serial;
                r_bad <= r_bad | !ok;
            end else begin
                r_sd0 <= serial;
                r_bad <= !ok;
            end
        end
        if (i_cmd.out_load) begin
            r_diff    <= r_bad ? '0 : clamped[DIFF_W-1:0];
            r_bad_out <= r_bad;
        end
    end

    assign o_day_difference = r_diff;
    assign o_bad_date       = r_bad_out;

endmodule

FILE: rtl/core/gdd_controller.sv
`timescale 1ns / 1ps
`include "gregorian_date_difference_unit_defines.svh"

module gdd_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gdd_pkg::t_dp_cmd o_cmd
);
    import gdd_pkg::*;

    t_state r_state, n_state;
    logic   r_sel, n_sel;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sel          = r_sel;
        o_cmd          = '0;
        o_cmd.sel      = r_sel;
        o_in_ready     = 1'b0;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel      = 1'b0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.acc = 1'b1;
                if (r_sel) begin
                    n_state = S_FIN;
                end else begin
                    n_sel   = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `GDD_ASSERT_NEXT(a_accept_starts_first, i_clk, i_rst_n,
        i_in_valid && o_in_ready, r_state == S_MUL && !r_sel)
    `GDD_ASSERT_NEXT(a_second_sum_finishes, i_clk, i_rst_n,
        r_state == S_SUM && r_sel, r_state == S_FIN)
    `GDD_ASSERT_NEXT(a_fin_waits_on_full, i_clk, i_rst_n,
        r_state == S_FIN && r_out_valid && !i_out_ready, r_state == S_FIN)
    `GDD_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n,
        o_cmd.out_load, r_out_valid && r_state == S_IDLE)

endmodule

FILE: rtl/core/gregorian_date_difference_unit.sv
`timescale 1ns / 1ps
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+---------------------------------------------
// in       | i_in_valid   | o_in_ready   | i_first_*, i_second_*, i_count_last_day
// out      | o_out_valid  | i_out_ready  | o_day_difference, o_bad_date
//
// an input transaction runs from accept to result as: load, then multiply and
// sum for each date in turn on one shared unit, then the final subtract into the output
// register. a new transaction is accepted the cycle after the result is loaded, so
// transactions never overlap: each is loaded into the output before the next is taken.
// reset (i_rst_n low, synchronous) returns the controller to idle and empties the output.
// a stalled output holds its result; the next transaction waits in the last step.

module gregorian_date_difference_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [gdd_pkg::YEAR_W-1:0]         i_first_year,
    input  logic [gdd_pkg::MONTH_W-1:0]        i_first_month,
    input  logic [gdd_pkg::DAY_W-1:0]          i_first_day,
    input  logic [gdd_pkg::YEAR_W-1:0]         i_second_year,
    input  logic [gdd_pkg::MONTH_W-1:0]        i_second_month,
    input  logic [gdd_pkg::DAY_W-1:0]          i_second_day,
    input  logic                               i_count_last_day,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [gdd_pkg::DIFF_W-1:0]  o_day_difference,
    output logic                               o_bad_date
);
    import gdd_pkg::*;

    t_dp_cmd cmd;

    gdd_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    gdd_datapath u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_first_year     (i_first_year),
        .i_first_month    (i_first_month),
        .i_first_day      (i_first_day),
        .i_second_year    (i_second_year),
        .i_second_month   (i_second_month),
        .i_second_day     (i_second_day),
        .i_count_last_day (i_count_last_day),
        .o_day_difference (o_day_difference),
        .o_bad_date       (o_bad_date)
    );

endmodule
